>>> rtl/gcla_pkg.sv
// Shared types and constants of the gyro-compensated linear acceleration unit.
// Used by gcla_ctrl, gcla_dp and the top level; depends on nothing else.
`default_nettype none

package gcla_pkg;

  // Port payload widths: 7 x 16 bit input fields, 3 x 32 + 3 x 17 + 16 bit results.
  localparam int InDataW  = 112;
  localparam int OutDataW = 168;

  localparam int LinLimit = 65535;
  localparam int RotShift = 10;
  localparam logic [15:0] RootTopBit = 16'h8000;

  // Last count value of each multi-cycle step.
  localparam logic [3:0] VelLast  = 4'd2;
  localparam logic [3:0] RotLast  = 4'd11;
  localparam logic [3:0] SqrLast  = 4'd2;
  localparam logic [3:0] RootLast = 4'd15;

  // Configuration register indexes.
  localparam logic [2:0] RegGyroScale = 3'd0;
  localparam logic [2:0] RegGyroShift = 3'd1;
  localparam logic [2:0] RegCoefYz    = 3'd2;
  localparam logic [2:0] RegCoefZy    = 3'd3;
  localparam logic [2:0] RegCoefXz    = 3'd4;
  localparam logic [2:0] RegCoefZx    = 3'd5;
  localparam logic [2:0] RegCoefXy    = 3'd6;
  localparam logic [2:0] RegCoefYx    = 3'd7;

  // Slots of the coefficient file.
  localparam logic [2:0] CoefYz = 3'd0;
  localparam logic [2:0] CoefZy = 3'd1;
  localparam logic [2:0] CoefXz = 3'd2;
  localparam logic [2:0] CoefZx = 3'd3;
  localparam logic [2:0] CoefXy = 3'd4;
  localparam logic [2:0] CoefYx = 3'd5;

  localparam logic [1:0] AxisX = 2'd0;
  localparam logic [1:0] AxisY = 2'd1;
  localparam logic [1:0] AxisZ = 2'd2;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_LOAD,
    OP_VEL,
    OP_DIFF,
    OP_ROT,
    OP_RSAT,
    OP_LIN,
    OP_SQR,
    OP_ROOT,
    OP_OUT
  } op_e;

  typedef struct packed {
    op_e        op;
    logic [3:0] idx;
  } cmd_t;

  typedef struct packed {
    logic hist_valid;
  } status_t;

  typedef struct packed {
    logic [1:0] axis;
    logic [2:0] coef;
    logic [1:0] dsel;
    logic       hi;
    logic       sub;
  } rot_term_t;

  // Rotation schedule: four partial products per axis. Each lever product is
  // split into the upper 17 bits of the velocity change (shifted by 16) and
  // the lower 16 bits; the second product of an axis is subtracted.
  function automatic rot_term_t rot_term(input logic [3:0] step);
    rot_term_t t;
    t      = '0;
    t.axis = step[3:2];
    t.hi   = ~step[0];
    t.sub  = step[1];
    unique case (step[3:1])
      3'd0:    begin t.coef = CoefZy; t.dsel = AxisY; end
      3'd1:    begin t.coef = CoefYz; t.dsel = AxisZ; end
      3'd2:    begin t.coef = CoefXz; t.dsel = AxisZ; end
      3'd3:    begin t.coef = CoefZx; t.dsel = AxisX; end
      3'd4:    begin t.coef = CoefYx; t.dsel = AxisX; end
      3'd5:    begin t.coef = CoefXy; t.dsel = AxisY; end
      default: begin t.coef = CoefYz; t.dsel = AxisX; end
    endcase
    return t;
  endfunction

endpackage

`default_nettype wire

>>> rtl/gyro_compensated_linear_accel_unit.sv
// Top level of the gyro-compensated linear acceleration unit.
// Joins the sequencer gcla_ctrl and the datapath gcla_dp; uses gcla_pkg.
//
//   Channel  Direction  Handshake                   Payload
//   s_axis   in         s_axis_tvalid/tready        tdata 112 bit, tuser gyro_on
//   m_axis   out        m_axis_tvalid/tready        tdata 168 bit
//   cfg      in         cfg_we_i (no wait)          cfg_idx_i, cfg_data_i
//
// One sample is in work at a time, through one shared multiplier. A gyro-off
// sample skips all arithmetic steps; a gyro-on sample without stored velocity
// skips the rotation. The 16-step root and the 12 rotation partial products are
// the longest steps of a gyro-on sample.
// Reset clears configuration, history and handshake state; a stalled result
// waits in the output register while the next sample is already being worked.
`default_nettype none

module gyro_compensated_linear_accel_unit (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           cfg_we_i,
  input  wire logic [2:0]                     cfg_idx_i,
  input  wire logic [23:0]                    cfg_data_i,
  input  wire logic                           s_axis_tvalid,
  output logic                                s_axis_tready,
  // gyro_x, gyro_y, gyro_z, accel_x, accel_y, accel_z, accel_mag
  input  wire logic [gcla_pkg::InDataW-1:0]   s_axis_tdata,
  // gyro_on
  input  wire logic                           s_axis_tuser,
  output logic                                m_axis_tvalid,
  input  wire logic                           m_axis_tready,
  // rot_x, rot_y, rot_z, lin_x, lin_y, lin_z, lin_mag, zero padding
  output logic [gcla_pkg::OutDataW-1:0]       m_axis_tdata
);

  gcla_pkg::cmd_t    cmd;
  gcla_pkg::status_t status;

  gcla_ctrl u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (s_axis_tvalid),
    .in_gyro_on_i (s_axis_tuser),
    .in_ready_o   (s_axis_tready),
    .out_ready_i  (m_axis_tready),
    .out_valid_o  (m_axis_tvalid),
    .status_i     (status),
    .cmd_o        (cmd)
  );

  gcla_dp u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_data_i   (cfg_data_i),
    .in_data_i    (s_axis_tdata),
    .in_gyro_on_i (s_axis_tuser),
    .cmd_i        (cmd),
    .status_o     (status),
    .out_data_o   (m_axis_tdata)
  );

endmodule

`default_nettype wire

>>> rtl/gcla_ctrl.sv
// Sequencer of the gyro-compensated linear acceleration unit.
// Issues one datapath command per cycle, OP_NONE while waiting; uses gcla_pkg.
`default_nettype none

module gcla_ctrl (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             in_valid_i,
  input  wire logic             in_gyro_on_i,
  output logic                  in_ready_o,
  input  wire logic             out_ready_i,
  output logic                  out_valid_o,
  input  wire gcla_pkg::status_t status_i,
  output gcla_pkg::cmd_t        cmd_o
);

  typedef enum logic [8:0] {
    ST_IDLE = 9'b000000001,
    ST_VEL  = 9'b000000010,
    ST_DIFF = 9'b000000100,
    ST_ROT  = 9'b000001000,
    ST_RSAT = 9'b000010000,
    ST_LIN  = 9'b000100000,
    ST_SQR  = 9'b001000000,
    ST_ROOT = 9'b010000000,
    ST_DONE = 9'b100000000
  } state_e;

  state_e         state_q, state_d;
  logic [3:0]     cnt_q, cnt_d;
  logic           out_valid_q, out_valid_d;
  logic           accept;
  logic           out_free;
  gcla_pkg::cmd_t cmd;

  assign in_ready_o  = (state_q == ST_IDLE);
  assign accept      = in_valid_i & in_ready_o;
  assign out_free    = ~out_valid_q | out_ready_i;
  assign out_valid_o = out_valid_q;
  assign cmd_o       = cmd;

  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    out_valid_d = out_valid_q & ~out_ready_i;
    cmd.op      = gcla_pkg::OP_NONE;
    cmd.idx     = cnt_q;
    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          cmd.op  = gcla_pkg::OP_LOAD;
          cnt_d   = '0;
          state_d = in_gyro_on_i ? ST_VEL : ST_DONE;
        end
      end
      ST_VEL: begin
        cmd.op = gcla_pkg::OP_VEL;
        if (cnt_q == gcla_pkg::VelLast) begin
          cnt_d   = '0;
          state_d = ST_DIFF;
        end else begin
          cnt_d = cnt_q + 4'd1;
        end
      end
      ST_DIFF: begin
        // Without a stored velocity the accumulators stay cleared.
        cmd.op  = gcla_pkg::OP_DIFF;
        state_d = status_i.hist_valid ? ST_ROT : ST_RSAT;
      end
      ST_ROT: begin
        cmd.op = gcla_pkg::OP_ROT;
        if (cnt_q == gcla_pkg::RotLast) begin
          cnt_d   = '0;
          state_d = ST_RSAT;
        end else begin
          cnt_d = cnt_q + 4'd1;
        end
      end
      ST_RSAT: begin
        cmd.op  = gcla_pkg::OP_RSAT;
        state_d = ST_LIN;
      end
      ST_LIN: begin
        cmd.op  = gcla_pkg::OP_LIN;
        cnt_d   = '0;
        state_d = ST_SQR;
      end
      ST_SQR: begin
        cmd.op = gcla_pkg::OP_SQR;
        if (cnt_q == gcla_pkg::SqrLast) begin
          cnt_d   = '0;
          state_d = ST_ROOT;
        end else begin
          cnt_d = cnt_q + 4'd1;
        end
      end
      ST_ROOT: begin
        cmd.op = gcla_pkg::OP_ROOT;
        if (cnt_q == gcla_pkg::RootLast) begin
          cnt_d   = '0;
          state_d = ST_DONE;
        end else begin
          cnt_d = cnt_q + 4'd1;
        end
      end
      ST_DONE: begin
        if (out_free) begin
          cmd.op      = gcla_pkg::OP_OUT;
          out_valid_d = 1'b1;
          state_d     = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
        cnt_d   = '0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

`ifndef SYNTHESIS
  // A gyro-off sample goes straight to the result stage.
  a_gyro_off_skips : assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && !in_gyro_on_i |=> state_q == ST_DONE)
    else $error("gyro-off sample did not skip to result stage");

  a_root_ends : assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_ROOT && cnt_q == gcla_pkg::RootLast |=> state_q == ST_DONE)
    else $error("root sequence did not end after its last step");

  a_result_posted : assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_DONE && out_free |=> out_valid_q && state_q == ST_IDLE)
    else $error("result not posted when output register was free");
`endif

endmodule

`default_nettype wire

>>> rtl/gcla_dp.sv
// Datapath of the gyro-compensated linear acceleration unit: configuration
// registers, one shared 24x17 signed multiplier, accumulators and result register.
// Uses gcla_pkg; driven by gcla_ctrl commands.
`default_nettype none

module gcla_dp (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            cfg_we_i,
  input  wire logic [2:0]                      cfg_idx_i,
  input  wire logic [23:0]                     cfg_data_i,
  input  wire logic [gcla_pkg::InDataW-1:0]    in_data_i,
  input  wire logic                            in_gyro_on_i,
  input  wire gcla_pkg::cmd_t                  cmd_i,
  output gcla_pkg::status_t                    status_o,
  output logic [gcla_pkg::OutDataW-1:0]        out_data_o
);

  localparam logic signed [33:0] LinHi = 34'(gcla_pkg::LinLimit);
  localparam logic signed [33:0] LinLo = -LinHi;

  // Configuration.
  logic [15:0]        scale_q;
  logic [4:0]         shift_q;
  logic signed [23:0] coef_q [6];
  logic               hist_q;

  // Working registers.
  logic [15:0]        gyro_q  [3];
  logic [15:0]        accel_q [3];
  logic [31:0]        vel_q   [3];
  logic [31:0]        prev_q  [3];
  logic [32:0]        d_q     [3];
  logic signed [57:0] acc_q   [3];
  logic [31:0]        rot_q   [3];
  logic [16:0]        lin_q   [3];
  logic [33:0]        sum_q;
  logic [15:0]        root_q;
  logic [15:0]        bit_q;
  logic [gcla_pkg::OutDataW-1:0] out_q;

  // Shared multiplier.
  logic signed [23:0] mul_a;
  logic signed [16:0] mul_b;
  logic signed [40:0] mul_p;

  gcla_pkg::rot_term_t term;
  logic [32:0]        d_sel;
  logic [16:0]        lin_sel;
  logic [15:0]        root_t;
  logic [31:0]        root_opnd;
  logic signed [40:0] vel_sh;
  logic signed [57:0] addend;
  logic signed [57:0] prod_ext;

  assign term      = gcla_pkg::rot_term(cmd_i.idx);
  assign d_sel     = d_q[term.dsel];
  assign lin_sel   = lin_q[cmd_i.idx[1:0]];
  assign root_t    = root_q | bit_q;
  assign root_opnd = (sum_q[33:32] != 2'b00) ? 32'hFFFF_FFFF : sum_q[31:0];
  assign status_o.hist_valid = hist_q;
  assign out_data_o = out_q;

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (cmd_i.op)
      gcla_pkg::OP_VEL: begin
        mul_a = {8'b0, scale_q};
        mul_b = {gyro_q[cmd_i.idx[1:0]][15], gyro_q[cmd_i.idx[1:0]]};
      end
      gcla_pkg::OP_ROT: begin
        mul_a = coef_q[term.coef];
        mul_b = term.hi ? d_sel[32:16] : {1'b0, d_sel[15:0]};
      end
      gcla_pkg::OP_SQR: begin
        mul_a = {{7{lin_sel[16]}}, lin_sel};
        mul_b = lin_sel;
      end
      gcla_pkg::OP_ROOT: begin
        mul_a = {8'b0, root_t};
        mul_b = {1'b0, root_t};
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign mul_p    = mul_a * mul_b;
  assign vel_sh   = mul_p >>> shift_q;
  assign prod_ext = {{17{mul_p[40]}}, mul_p};
  assign addend   = term.hi ? {prod_ext[41:0], 16'b0} : prod_ext;

  // Arithmetic shift by the rotation scale, then saturate to 32 bits.
  function automatic logic [31:0] rot_sat(input logic signed [57:0] acc);
    logic signed [57:0] sh;
    sh = acc >>> gcla_pkg::RotShift;
    if ((&sh[57:31]) || !(|sh[57:31])) begin
      return sh[31:0];
    end
    return sh[57] ? 32'h8000_0000 : 32'h7FFF_FFFF;
  endfunction

  function automatic logic [16:0] lin_clamp(input logic [15:0] a, input logic [31:0] r);
    logic signed [33:0] diff;
    diff = $signed({{18{a[15]}}, a}) - $signed({{2{r[31]}}, r});
    if (diff > LinHi) begin
      return LinHi[16:0];
    end
    if (diff < LinLo) begin
      return LinLo[16:0];
    end
    return diff[16:0];
  endfunction

  // Configuration and history flag.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scale_q <= '0;
      shift_q <= '0;
      for (int i = 0; i < 6; i++) begin
        coef_q[i] <= '0;
      end
      hist_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          gcla_pkg::RegGyroScale: scale_q <= cfg_data_i[15:0];
          gcla_pkg::RegGyroShift: shift_q <= cfg_data_i[4:0];
          gcla_pkg::RegCoefYz:    coef_q[gcla_pkg::CoefYz] <= cfg_data_i;
          gcla_pkg::RegCoefZy:    coef_q[gcla_pkg::CoefZy] <= cfg_data_i;
          gcla_pkg::RegCoefXz:    coef_q[gcla_pkg::CoefXz] <= cfg_data_i;
          gcla_pkg::RegCoefZx:    coef_q[gcla_pkg::CoefZx] <= cfg_data_i;
          gcla_pkg::RegCoefXy:    coef_q[gcla_pkg::CoefXy] <= cfg_data_i;
          gcla_pkg::RegCoefYx:    coef_q[gcla_pkg::CoefYx] <= cfg_data_i;
          default: ;
        endcase
      end
      if (cmd_i.op == gcla_pkg::OP_LOAD && !in_gyro_on_i) begin
        hist_q <= 1'b0;
      end else if (cmd_i.op == gcla_pkg::OP_DIFF) begin
        hist_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    case (cmd_i.op)
      gcla_pkg::OP_LOAD: begin
        for (int i = 0; i < 3; i++) begin
          gyro_q[i]  <= in_data_i[16*i +: 16];
          accel_q[i] <= in_data_i[48 + 16*i +: 16];
        end
        if (in_gyro_on_i) begin
          for (int i = 0; i < 3; i++) begin
            acc_q[i] <= '0;
          end
          sum_q  <= '0;
          root_q <= '0;
          bit_q  <= gcla_pkg::RootTopBit;
        end else begin
          // Pass-through: raw readings and the supplied magnitude.
          for (int i = 0; i < 3; i++) begin
            lin_q[i] <= {in_data_i[48 + 16*i + 15], in_data_i[48 + 16*i +: 16]};
            rot_q[i] <= '0;
          end
          root_q <= in_data_i[96 +: 16];
        end
      end
      gcla_pkg::OP_VEL: begin
        vel_q[cmd_i.idx[1:0]] <= vel_sh[31:0];
      end
      gcla_pkg::OP_DIFF: begin
        for (int i = 0; i < 3; i++) begin
          d_q[i]    <= {vel_q[i][31], vel_q[i]} - {prev_q[i][31], prev_q[i]};
          prev_q[i] <= vel_q[i];
        end
      end
      gcla_pkg::OP_ROT: begin
        if (term.sub) begin
          acc_q[term.axis] <= acc_q[term.axis] - addend;
        end else begin
          acc_q[term.axis] <= acc_q[term.axis] + addend;
        end
      end
      gcla_pkg::OP_RSAT: begin
        for (int i = 0; i < 3; i++) begin
          rot_q[i] <= rot_sat(acc_q[i]);
        end
      end
      gcla_pkg::OP_LIN: begin
        for (int i = 0; i < 3; i++) begin
          lin_q[i] <= lin_clamp(accel_q[i], rot_q[i]);
        end
      end
      gcla_pkg::OP_SQR: begin
        // Squares are nonnegative and below 2^32.
        sum_q <= sum_q + mul_p[33:0];
      end
      gcla_pkg::OP_ROOT: begin
        if (mul_p[31:0] <= root_opnd) begin
          root_q <= root_t;
        end
        bit_q <= bit_q >> 1;
      end
      gcla_pkg::OP_OUT: begin
        out_q <= {5'b0, root_q, lin_q[2], lin_q[1], lin_q[0], rot_q[2], rot_q[1], rot_q[0]};
      end
      default: ;
    endcase
  end

`ifndef SYNTHESIS
  a_root_bit_onehot : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.op == gcla_pkg::OP_ROOT |-> $onehot(bit_q))
    else $error("root trial bit is not one-hot");
`endif

endmodule

`default_nettype wire

>>> test/gcla_result_checker.sv
// Result checker for the gyro-compensated linear acceleration unit testbench.
// Watches the config port and both stream channels, predicts every result beat
// from its own copy of registers and velocity history; uses gcla_pkg.
module gcla_result_checker
  import gcla_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [2:0]          cfg_idx_i,
  input  logic [23:0]         cfg_data_i,
  input  logic                s_axis_tvalid,
  input  logic                s_axis_tready,
  // gyro_x, gyro_y, gyro_z, accel_x, accel_y, accel_z, accel_mag
  input  logic [InDataW-1:0]  s_axis_tdata,
  // gyro_on
  input  logic                s_axis_tuser,
  input  logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  // rot_x, rot_y, rot_z, lin_x, lin_y, lin_z, lin_mag, zero padding
  input  logic [OutDataW-1:0] m_axis_tdata,
  output int                  pending_o,
  output int                  mismatches_o
);

  localparam longint RotMax = 64'sd2147483647;
  localparam longint RotMin = -64'sd2147483648;

  // Same field layout as the result beat: rot_x in the lowest bits, lin_mag in the highest.
  typedef struct packed {
    logic [15:0]        lin_mag;
    logic signed [16:0] lin_z;
    logic signed [16:0] lin_y;
    logic signed [16:0] lin_x;
    logic signed [31:0] rot_z;
    logic signed [31:0] rot_y;
    logic signed [31:0] rot_x;
  } lin_accel_t;

  logic [15:0]        gyro_scale;
  logic [4:0]         gyro_shift;
  logic signed [23:0] lever [6];
  logic signed [31:0] last_vel [3];
  logic               history_ok;
  lin_accel_t         expected_q [$];
  int                 mismatch_count = 0;

  assign mismatches_o = mismatch_count;

  task automatic report_mismatch(input string msg);
    $display("%0t: MISMATCH %s", $time, msg);
    mismatch_count++;
  endtask

  task automatic check_field(input string field, input logic [31:0] got,
                             input logic [31:0] want);
    if (got !== want)
      report_mismatch($sformatf("%s got %h expected %h", field, got, want));
  endtask

  function automatic longint limit(input longint v, input longint lo, input longint hi);
    return (v < lo) ? lo : ((v > hi) ? hi : v);
  endfunction

  function automatic logic signed [31:0] ang_vel(input logic signed [15:0] rate);
    longint prod;
    prod = longint'($signed({1'b0, gyro_scale})) * longint'(rate);
    return 32'(prod >>> gyro_shift);
  endfunction

  // Difference of two lever products, scaled down and held to 32 signed bits.
  function automatic longint lever_term(input logic [2:0] ca, input longint da,
                                        input logic [2:0] cb, input longint db);
    longint acc;
    acc = (longint'(lever[ca]) * da - longint'(lever[cb]) * db) >>> RotShift;
    return limit(acc, RotMin, RotMax);
  endfunction

  function automatic logic [15:0] isqrt16(input longint operand);
    logic [15:0] root;
    logic [15:0] probe;
    logic [15:0] trial;
    root  = '0;
    probe = RootTopBit;
    while (probe != 0) begin
      trial = root | probe;
      if (longint'(trial) * longint'(trial) <= operand) root = trial;
      probe = probe >> 1;
    end
    return root;
  endfunction

  function automatic lin_accel_t compensate(input logic gyro_on,
                                            input logic [InDataW-1:0] d);
    lin_accel_t         r;
    logic signed [31:0] vel [3];
    logic signed [15:0] accel [3];
    longint             dv [3];
    longint             rot [3];
    longint             lin [3];
    longint             sum;
    for (int a = 0; a < 3; a++) begin
      accel[a] = d[48 + 16 * a +: 16];
      rot[a]   = 0;
    end
    if (gyro_on) begin
      for (int a = 0; a < 3; a++) vel[a] = ang_vel(d[16 * a +: 16]);
      // The first sample of a gyro-on run has no history and gives no rotation.
      if (history_ok) begin
        for (int a = 0; a < 3; a++) dv[a] = longint'(vel[a]) - longint'(last_vel[a]);
        rot[AxisX] = lever_term(CoefZy, dv[AxisY], CoefYz, dv[AxisZ]);
        rot[AxisY] = lever_term(CoefXz, dv[AxisZ], CoefZx, dv[AxisX]);
        rot[AxisZ] = lever_term(CoefYx, dv[AxisX], CoefXy, dv[AxisY]);
      end
      history_ok = 1'b1;
      sum = 0;
      for (int a = 0; a < 3; a++) begin
        last_vel[a] = vel[a];
        lin[a] = limit(longint'(accel[a]) - rot[a], -LinLimit, LinLimit);
        sum += lin[a] * lin[a];
      end
      if (sum > 64'sh0_FFFF_FFFF) sum = 64'sh0_FFFF_FFFF;
      r.lin_mag = isqrt16(sum);
    end else begin
      // Pass-through; the stored velocities stay but are no longer trusted.
      for (int a = 0; a < 3; a++) lin[a] = longint'(accel[a]);
      r.lin_mag  = d[96 +: 16];
      history_ok = 1'b0;
    end
    r.rot_x = 32'(rot[AxisX]);
    r.rot_y = 32'(rot[AxisY]);
    r.rot_z = 32'(rot[AxisZ]);
    r.lin_x = 17'(lin[AxisX]);
    r.lin_y = 17'(lin[AxisY]);
    r.lin_z = 17'(lin[AxisZ]);
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    lin_accel_t seen;
    lin_accel_t want;
    if (!rst_ni) begin
      gyro_scale = '0;
      gyro_shift = '0;
      history_ok = 1'b0;
      for (int i = 0; i < 6; i++) lever[i] = '0;
      for (int a = 0; a < 3; a++) last_vel[a] = '0;
      expected_q.delete();
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          RegGyroScale: gyro_scale = cfg_data_i[15:0];
          RegGyroShift: gyro_shift = cfg_data_i[4:0];
          // Lever registers sit in the same order as the coefficient slots.
          default:      lever[cfg_idx_i - RegCoefYz] = cfg_data_i;
        endcase
      end
      if (s_axis_tvalid && s_axis_tready)
        expected_q.push_back(compensate(s_axis_tuser, s_axis_tdata));
      if (m_axis_tvalid && m_axis_tready) begin
        seen = lin_accel_t'(m_axis_tdata[$bits(lin_accel_t)-1:0]);
        if (expected_q.size() == 0) begin
          report_mismatch("result beat with no sample waiting");
        end else begin
          want = expected_q.pop_front();
          check_field("rot_x", 32'(seen.rot_x), 32'(want.rot_x));
          check_field("rot_y", 32'(seen.rot_y), 32'(want.rot_y));
          check_field("rot_z", 32'(seen.rot_z), 32'(want.rot_z));
          check_field("lin_x", 32'(seen.lin_x), 32'(want.lin_x));
          check_field("lin_y", 32'(seen.lin_y), 32'(want.lin_y));
          check_field("lin_z", 32'(seen.lin_z), 32'(want.lin_z));
          check_field("lin_mag", 32'(seen.lin_mag), 32'(want.lin_mag));
        end
      end
    end
    pending_o <= expected_q.size();
  end

endmodule

>>> test/gyro_compensated_linear_accel_unit_tb.sv
// Testbench top of the gyro-compensated linear acceleration unit.
// Drives config writes and sample beats, throttles the result side, and gives
// the verdict from gcla_result_checker; uses gcla_pkg and the unit's RTL.
module gyro_compensated_linear_accel_unit_tb;
  import gcla_pkg::*;

  localparam int QuietLimit = 5000;
  localparam int PhaseItems = 300;

  typedef struct packed {
    logic [15:0]        accel_mag;
    logic signed [15:0] accel_z;
    logic signed [15:0] accel_y;
    logic signed [15:0] accel_x;
    logic signed [15:0] gyro_z;
    logic signed [15:0] gyro_y;
    logic signed [15:0] gyro_x;
  } imu_sample_t;

  logic                clk_i         = 1'b0;
  logic                rst_ni        = 1'b0;
  logic                cfg_we_i      = 1'b0;
  logic [2:0]          cfg_idx_i     = RegGyroScale;
  logic [23:0]         cfg_data_i    = '0;
  logic                s_axis_tvalid = 1'b0;
  logic                s_axis_tready;
  logic [InDataW-1:0]  s_axis_tdata  = '0;
  logic                s_axis_tuser  = 1'b0;
  logic                m_axis_tvalid;
  logic                m_axis_tready = 1'b0;
  logic [OutDataW-1:0] m_axis_tdata;
  logic                calm          = 1'b0;
  int                  pending;
  int                  mismatches;
  int                  quiet         = 0;
  logic [23:0]         setting [8];
  logic signed [15:0]  gyro_last [3];

  always #5 clk_i = ~clk_i;

  gyro_compensated_linear_accel_unit DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  gcla_result_checker u_checker (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .pending_o     (pending),
    .mismatches_o  (mismatches)
  );

  always @(posedge clk_i) m_axis_tready <= calm || ($urandom_range(99) >= 8);

  // Watchdog: too long without any beat on either channel means a hang.
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      quiet <= 0;
    end else if (quiet >= QuietLimit) begin
      $display("gyro_compensated_linear_accel_unit verification failed");
      $finish;
    end else begin
      quiet <= quiet + 1;
    end
  end

  // Valid stays high from one beat to the next unless an idle gap is drawn.
  task automatic send_sample(input logic gyro_on, input imu_sample_t smp);
    if (!calm) begin
      while ($urandom_range(99) < 8) begin
        s_axis_tvalid <= 1'b0;
        @(posedge clk_i);
      end
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= smp;
    s_axis_tuser  <= gyro_on;
    do @(posedge clk_i); while (!s_axis_tready);
  endtask

  task automatic settle();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
  endtask

  task automatic apply_setting();
    settle();
    repeat (40) @(posedge clk_i);
    for (int i = RegGyroScale; i <= RegCoefYx; i++) begin
      cfg_we_i   <= 1'b1;
      cfg_idx_i  <= 3'(i);
      cfg_data_i <= setting[i];
      @(posedge clk_i);
    end
    cfg_we_i <= 1'b0;
  endtask

  task automatic directed(input logic gyro_on, input logic signed [15:0] gx,
                          input logic signed [15:0] gy, input logic signed [15:0] gz,
                          input logic signed [15:0] ax, input logic signed [15:0] ay,
                          input logic signed [15:0] az, input logic [15:0] mag);
    imu_sample_t smp;
    smp = '{accel_mag: mag, accel_z: az, accel_y: ay, accel_x: ax,
            gyro_z: gz, gyro_y: gy, gyro_x: gx};
    send_sample(gyro_on, smp);
  endtask

  function automatic logic signed [15:0] extreme16();
    case ($urandom_range(3))
      0:       return 16'sh8000;
      1:       return 16'sh7FFF;
      2:       return 16'sh0000;
      default: return 16'shFFFF;
    endcase
  endfunction

  // Mostly a smooth rate track, so the rotation term sees realistic changes.
  function automatic logic signed [15:0] next_rate(input logic signed [15:0] last);
    logic signed [15:0] step;
    int                 sel;
    sel  = $urandom_range(99);
    step = $urandom;
    if (sel < 65) return last + (step >>> $urandom_range(15, 5));
    if (sel < 75) return extreme16();
    return step;
  endfunction

  function automatic logic signed [15:0] pick_accel();
    logic signed [15:0] v;
    int                 sel;
    sel = $urandom_range(99);
    v   = $urandom;
    if (sel < 10) return extreme16();
    if (sel < 60) return v >>> $urandom_range(15, 0);
    return v;
  endfunction

  function automatic logic [23:0] rand_lever();
    logic signed [23:0] v;
    v = $urandom;
    return v >>> $urandom_range(23, 0);
  endfunction

  task automatic random_sample();
    imu_sample_t smp;
    logic        gyro_on;
    gyro_on = ($urandom_range(99) < 88);
    for (int a = 0; a < 3; a++) gyro_last[a] = next_rate(gyro_last[a]);
    smp.gyro_x    = gyro_last[AxisX];
    smp.gyro_y    = gyro_last[AxisY];
    smp.gyro_z    = gyro_last[AxisZ];
    smp.accel_x   = pick_accel();
    smp.accel_y   = pick_accel();
    smp.accel_z   = pick_accel();
    smp.accel_mag = $urandom;
    send_sample(gyro_on, smp);
  endtask

  initial begin
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Full scale with opposite extreme levers: saturated rotation and clamping.
    setting[RegGyroScale] = 24'hFFFF;
    setting[RegGyroShift] = '0;
    setting[RegCoefYz]    = 24'h7FFFFF;
    setting[RegCoefZy]    = 24'h800000;
    setting[RegCoefXz]    = 24'h7FFFFF;
    setting[RegCoefZx]    = 24'h800000;
    setting[RegCoefXy]    = 24'h7FFFFF;
    setting[RegCoefYx]    = 24'h800000;
    apply_setting();
    directed(1'b0, 0, 0, 0, -32768, 32767, 0, 16'hFFFF);
    directed(1'b0, 32767, -32768, -1, 32767, -32768, -1, 16'h0000);
    directed(1'b1, -32768, -32768, -32768, -32768, 32767, -32768, 16'h0000);
    directed(1'b1, 32767, 32767, 32767, 32767, -32768, 0, 16'h0000);
    directed(1'b1, -32768, 32767, 0, 0, 0, 0, 16'h0000);
    directed(1'b1, -32768, 32767, 0, 1, -1, 100, 16'h0000);
    directed(1'b1, -32767, 32767, 0, 0, 0, 0, 16'h0000);
    directed(1'b0, 5, 5, 5, 100, 200, 300, 16'd1234);
    directed(1'b1, 32767, -32768, 32767, -5, 7, 9, 16'h0000);
    directed(1'b1, 32767, -32768, 32766, 0, 0, 0, 16'h0000);
    directed(1'b1, 0, 0, 0, -32768, -32768, -32768, 16'h0000);

    for (int a = 0; a < 3; a++) gyro_last[a] = '0;
    for (int p = 0; p < 6; p++) begin
      setting[RegGyroScale] = $urandom;
      setting[RegGyroShift] = $urandom_range(31);
      for (int i = RegCoefYz; i <= RegCoefYx; i++) setting[i] = rand_lever();
      case (p)
        1: begin
          setting[RegGyroShift] = '0;
          setting[RegGyroScale] = 24'hFFFF;
          for (int i = RegCoefYz; i <= RegCoefYx; i++) setting[i] = 24'h7FFFFF;
        end
        2: begin
          setting[RegGyroScale] = '0;
          for (int i = RegCoefYz; i <= RegCoefYx; i++) setting[i] = 24'h800000;
        end
        4: begin
          setting[RegGyroScale] = 24'hFFFF;
          setting[RegGyroShift] = 24'd31;
          for (int i = RegCoefYz; i <= RegCoefYx; i++)
            setting[i] = (i % 2 == 0) ? 24'h7FFFFF : 24'h800000;
        end
        5: setting[RegGyroShift] = $urandom_range(16, 8);
        default: ;
      endcase
      calm <= (p == 3);
      apply_setting();
      for (int n = 0; n < PhaseItems; n++) begin
        // Let the unit drain completely once in the middle of the first run.
        if (p == 0 && n == PhaseItems / 2) settle();
        random_sample();
      end
    end

    settle();
    repeat (60) @(posedge clk_i);
    if (mismatches == 0)
      $display("gyro_compensated_linear_accel_unit verification clean");
    else
      $display("gyro_compensated_linear_accel_unit verification failed");
    $finish;
  end

endmodule

>>> gyro_compensated_linear_accel_unit.f
rtl/gcla_pkg.sv
rtl/gcla_ctrl.sv
rtl/gcla_dp.sv
rtl/gyro_compensated_linear_accel_unit.sv
test/gcla_result_checker.sv
test/gyro_compensated_linear_accel_unit_tb.sv
